// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the normal vector quantizer RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define NVQ_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error("assertion failed");
`define NVQ_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define NVQ_ASSERT_ALWAYS(lbl, cond)
`define NVQ_ASSERT_IMPLY(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/nvq_pkg.sv =====
// Shared constants, sector codes and stage structs of the normal vector quantizer.
// No dependencies.
package nvq_pkg;

  localparam int MAX_LEVEL = 14;
  localparam int FRAC_BITS = 24;
  localparam int QW        = FRAC_BITS + 1;  // simplex coordinate width, holds 1.0
  localparam int MAGW      = 16;             // |component|, up to 32768
  localparam int SUMW      = 17;             // sum of three magnitudes
  localparam int RW        = SUMW + 1;       // partial remainder, below twice the sum
  localparam int LVLW      = 4;
  localparam int CODEW     = 31;

  localparam logic [1:0] SEC_X   = 2'd0;
  localparam logic [1:0] SEC_Y   = 2'd1;
  localparam logic [1:0] SEC_Z   = 2'd2;
  localparam logic [1:0] SEC_MID = 2'd3;

  // One divider stage: three remainders against one shared divisor
  typedef struct packed {
    logic                     valid;
    logic [2:0]               signs;
    logic [LVLW-1:0]          lvl;
    logic                     zero;
    logic [SUMW-1:0]          sum;
    logic [2:0][RW-1:0]       r;
    logic [2:0][QW-1:0]       q;
  } nvq_div_t;

  // One subdivision stage: point, current triangle box and code so far
  typedef struct packed {
    logic                     valid;
    logic [LVLW-1:0]          lvl;
    logic [LVLW-1:0]          left;
    logic                     zero;
    logic [2:0][QW-1:0]       p;
    logic [2:0][QW-1:0]       lo;
    logic [2:0][QW-1:0]       hi;
    logic                     flip;
    logic [CODEW-1:0]         code;
  } nvq_split_t;

endpackage

// ===== hw/rtl/normal_vector_quantizer_unit.sv =====
// Normal vector quantizer: takes one signed Q1.15 vector per transaction and returns an
// octant-plus-simplex code of 3+2*level bits, level being quant_level capped at 14. The
// datapath is a chain of 25 division cells (one quotient bit each) followed by 14
// subdivision cells (one level each), so a transaction is accepted every cycle unless
// in_stall is high; the whole chain holds while a finished result is stalled. Depends on
// nvq_pkg, nvq_div_cell, nvq_split_cell and assert_macros.svh.
`include "assert_macros.svh"
module normal_vector_quantizer_unit
  import nvq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [LVLW-1:0]   cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CODEW-1:0]  normal_code
);

  logic [LVLW-1:0] quant_level;
  logic            advance;
  logic [MAGW-1:0] mag [3];
  logic [LVLW-1:0] lvl_sat;
  nvq_div_t        div_in;
  nvq_div_t        div_s [QW+1];
  nvq_split_t      split_s [MAX_LEVEL+1];

  // Hold the level register
  always_ff @(posedge clk) begin
    if (rst) begin
      quant_level <= LVLW'(9);
    end else if (cfg_wr_en) begin
      quant_level <= cfg_wr_data;
    end
  end

  // Stall the whole chain while the result is stalled
  assign advance  = !(split_s[MAX_LEVEL].valid && out_stall);
  assign in_stall = !advance;

  // Build the entry stage: magnitudes, sum, saturated level
  always_comb begin
    mag[0]  = normal_x[15] ? MAGW'(~normal_x + 16'd1) : MAGW'(normal_x);
    mag[1]  = normal_y[15] ? MAGW'(~normal_y + 16'd1) : MAGW'(normal_y);
    mag[2]  = normal_z[15] ? MAGW'(~normal_z + 16'd1) : MAGW'(normal_z);
    lvl_sat = (quant_level > LVLW'(MAX_LEVEL)) ? LVLW'(MAX_LEVEL) : quant_level;
    div_in.valid = in_valid;
    div_in.signs = {normal_x[15], normal_y[15], normal_z[15]};
    div_in.lvl   = lvl_sat;
    div_in.sum   = SUMW'(mag[0]) + SUMW'(mag[1]) + SUMW'(mag[2]);
    div_in.zero  = (div_in.sum == '0);
    for (int i = 0; i < 3; i++) begin
      div_in.r[i] = RW'(mag[i]);
      div_in.q[i] = '0;
    end
  end

  assign div_s[0] = div_in;

  for (genvar g = 0; g < QW; g++) begin : g_div
    nvq_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .din     (div_s[g]),
      .dout    (div_s[g+1])
    );
  end

  // Start each point in the full simplex box
  always_comb begin
    split_s[0].valid = div_s[QW].valid;
    split_s[0].lvl   = div_s[QW].lvl;
    split_s[0].left  = div_s[QW].lvl;
    split_s[0].zero  = div_s[QW].zero;
    split_s[0].p     = div_s[QW].q;
    split_s[0].flip  = 1'b0;
    split_s[0].code  = CODEW'(div_s[QW].signs);
    for (int i = 0; i < 3; i++) begin
      split_s[0].lo[i] = '0;
      split_s[0].hi[i] = QW'(1) << FRAC_BITS;
    end
  end

  for (genvar g = 0; g < MAX_LEVEL; g++) begin : g_split
    nvq_split_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .din     (split_s[g]),
      .dout    (split_s[g+1])
    );
  end

  // Drop the code for level zero and the zero vector
  assign out_valid   = split_s[MAX_LEVEL].valid;
  assign normal_code = (split_s[MAX_LEVEL].lvl == '0 || split_s[MAX_LEVEL].zero) ?
                       '0 : split_s[MAX_LEVEL].code;

  `NVQ_ASSERT_IMPLY(a_code_width, out_valid,
    (normal_code >> (6'd3 + {1'b0, split_s[MAX_LEVEL].lvl, 1'b0})) == '0)
  `NVQ_ASSERT_IMPLY(a_levels_done, out_valid, split_s[MAX_LEVEL].left == '0)
  `NVQ_ASSERT_IMPLY(a_simplex_sum, div_s[QW].valid && !div_s[QW].zero,
    ((27'(div_s[QW].q[0]) + 27'(div_s[QW].q[1]) + 27'(div_s[QW].q[2])) <=
      (27'(1) << FRAC_BITS)) &&
    ((27'(div_s[QW].q[0]) + 27'(div_s[QW].q[1]) + 27'(div_s[QW].q[2]) + 27'd2) >=
      (27'(1) << FRAC_BITS)))

endmodule

// ===== hw/rtl/nvq_div_cell.sv =====
// One restoring-division cell: produces one quotient bit for each of three components.
// Depends on nvq_pkg.
module nvq_div_cell
  import nvq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     advance,
  input  nvq_div_t din,
  output nvq_div_t dout
);

  nvq_div_t nxt;
  logic [RW-1:0] rr [3];
  logic [2:0]    ge;

  // Compare, subtract and shift the remainder
  always_comb begin
    nxt = din;
    for (int i = 0; i < 3; i++) begin
      ge[i]    = din.r[i] >= {1'b0, din.sum};
      rr[i]    = ge[i] ? din.r[i] - {1'b0, din.sum} : din.r[i];
      nxt.r[i] = {rr[i][RW-2:0], 1'b0};
      nxt.q[i] = {din.q[i][QW-2:0], ge[i]};
    end
  end

  // Advance the stage
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (advance) begin
      dout.valid <= din.valid;
    end
    if (advance) begin
      dout.signs <= nxt.signs;
      dout.lvl   <= nxt.lvl;
      dout.zero  <= nxt.zero;
      dout.sum   <= nxt.sum;
      dout.r     <= nxt.r;
      dout.q     <= nxt.q;
    end
  end

endmodule

// ===== hw/rtl/nvq_split_cell.sv =====
// One simplex subdivision cell: while levels remain, picks a two-bit sector and shrinks the triangle box.
// Depends on nvq_pkg.
module nvq_split_cell
  import nvq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  nvq_split_t din,
  output nvq_split_t dout
);

  nvq_split_t nxt;
  logic [2:0][QW-1:0] half;
  logic [1:0]         s;

  always_comb begin
    nxt = din;
    for (int i = 0; i < 3; i++) begin
      half[i] = QW'(({1'b0, din.lo[i]} + {1'b0, din.hi[i]}) >> 1);
    end
    // Pick the sector, tests reversed in the inverted triangle
    if (din.flip) begin
      priority if (din.p[2] < half[2]) s = SEC_Z;
      else if (din.p[1] < half[1]) s = SEC_Y;
      else if (din.p[0] < half[0]) s = SEC_X;
      else s = SEC_MID;
    end else begin
      priority if (din.p[2] > half[2]) s = SEC_Z;
      else if (din.p[1] > half[1]) s = SEC_Y;
      else if (din.p[0] > half[0]) s = SEC_X;
      else s = SEC_MID;
    end
    // Shrink the box only while levels remain
    if (din.left != '0) begin
      nxt.left = din.left - LVLW'(1);
      nxt.code = {din.code[CODEW-3:0], s};
      if (din.flip) begin
        nxt.lo = half;
        if (s == SEC_MID) begin
          nxt.flip = 1'b0;
        end else begin
          nxt.hi[s] = half[s];
          nxt.lo[s] = din.lo[s];
        end
      end else begin
        nxt.hi = half;
        if (s == SEC_MID) begin
          nxt.flip = 1'b1;
        end else begin
          nxt.lo[s] = half[s];
          nxt.hi[s] = din.hi[s];
        end
      end
    end
  end

  // Advance the stage
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (advance) begin
      dout.valid <= din.valid;
    end
    if (advance) begin
      dout.lvl  <= nxt.lvl;
      dout.left <= nxt.left;
      dout.zero <= nxt.zero;
      dout.p    <= nxt.p;
      dout.lo   <= nxt.lo;
      dout.hi   <= nxt.hi;
      dout.flip <= nxt.flip;
      dout.code <= nxt.code;
    end
  end

endmodule

// ===== tb/tb_normal_vector_quantizer_unit.sv =====
// Testbench for normal_vector_quantizer_unit: directed table, then random vectors, each code
// checked against a behavioral quantizer. Depends on nvq_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_normal_vector_quantizer_unit
  import nvq_pkg::*;
;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               has_code;
    logic [CODEW-1:0]   code;
  } vec_row_t;

  localparam int LATENCY    = 39;
  localparam int CYCLE_CAP  = 600000;
  localparam int N_RANDOM   = 1400;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_wr_en = 1'b0;
  logic [LVLW-1:0]         cfg_wr_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [15:0]      normal_x = '0;
  logic signed [15:0]      normal_y = '0;
  logic signed [15:0]      normal_z = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [CODEW-1:0]        normal_code;

  logic [LVLW-1:0]         level_reg;
  logic [CODEW-1:0]        pending_codes[$];
  int                      fail_count = 0;
  int                      cycle_count = 0;
  bit                      quiet_tail = 1'b0;
  bit                      hold_receiver = 1'b0;
  vec_row_t                dir_rows[$];

  normal_vector_quantizer_unit DUT (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .out_valid(out_valid), .out_stall(out_stall), .normal_code(normal_code)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Compute the octant and simplex sector code of one vector at a given level
  function automatic logic [CODEW-1:0] octant_code(logic signed [15:0] vx,
      logic signed [15:0] vy, logic signed [15:0] vz, logic [LVLW-1:0] lv_in);
    logic [16:0] ax, ay, az;
    logic [17:0] total;
    logic [63:0] pt[3];
    logic [63:0] lo[3];
    logic [63:0] hi[3];
    logic [63:0] mid[3];
    logic [63:0] keep;
    logic [63:0] code;
    logic [1:0]  sec;
    logic        flipped;
    int          lv;
    lv = (lv_in > MAX_LEVEL) ? MAX_LEVEL : int'(lv_in);
    if (lv == 0) return '0;
    ax = vx[15] ? 17'(-$signed({1'b1, vx})) : {1'b0, vx};
    ay = vy[15] ? 17'(-$signed({1'b1, vy})) : {1'b0, vy};
    az = vz[15] ? 17'(-$signed({1'b1, vz})) : {1'b0, vz};
    code = {61'd0, vx[15], vy[15], vz[15]};
    total = ax + ay + az;
    if (total == '0) return CODEW'(code << (2 * lv));
    pt[0] = (64'(ax) << FRAC_BITS) / total;
    pt[1] = (64'(ay) << FRAC_BITS) / total;
    pt[2] = (64'(az) << FRAC_BITS) / total;
    for (int i = 0; i < 3; i++) begin
      lo[i] = '0;
      hi[i] = 64'd1 << FRAC_BITS;
    end
    flipped = 1'b0;
    for (int k = 0; k < lv; k++) begin
      for (int i = 0; i < 3; i++) mid[i] = (lo[i] + hi[i]) >> 1;
      sec = SEC_MID;
      if (flipped) begin
        if (pt[2] < mid[2]) sec = SEC_Z;
        else if (pt[1] < mid[1]) sec = SEC_Y;
        else if (pt[0] < mid[0]) sec = SEC_X;
      end else begin
        if (pt[2] > mid[2]) sec = SEC_Z;
        else if (pt[1] > mid[1]) sec = SEC_Y;
        else if (pt[0] > mid[0]) sec = SEC_X;
      end
      code = (code << 2) | 64'(sec);
      // Shrink the triangle toward the chosen corner, or invert for the middle one
      if (flipped) begin
        keep = (sec != SEC_MID) ? lo[sec] : '0;
        for (int i = 0; i < 3; i++) lo[i] = mid[i];
        if (sec != SEC_MID) begin
          hi[sec] = lo[sec];
          lo[sec] = keep;
        end else flipped = 1'b0;
      end else begin
        keep = (sec != SEC_MID) ? hi[sec] : '0;
        for (int i = 0; i < 3; i++) hi[i] = mid[i];
        if (sec != SEC_MID) begin
          lo[sec] = hi[sec];
          hi[sec] = keep;
        end else flipped = 1'b1;
      end
    end
    return CODEW'(code);
  endfunction

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Compare each delivered code with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_codes.size() == 0) begin
        $error("normal_code: no transaction expected, actual %h", normal_code);
        fail_count++;
      end else begin
        logic [CODEW-1:0] want;
        want = pending_codes.pop_front();
        if (want !== normal_code) begin
          $error("normal_code: expected %h actual %h", want, normal_code);
          fail_count++;
        end
      end
    end
  end

  // Stall the output in random bursts, with one long hold-off on request
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_receiver) begin
        out_stall <= 1'b1;
        repeat (150) @(posedge clk);
        out_stall <= 1'b0;
        hold_receiver = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 12);
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one vector and hold it until accepted; record expectation on acceptance
  task automatic send_vector(logic signed [15:0] vx, logic signed [15:0] vy,
      logic signed [15:0] vz, logic has_code, logic [CODEW-1:0] code);
    logic [CODEW-1:0] want;
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    normal_x <= vx;
    normal_y <= vy;
    normal_z <= vz;
    in_valid <= 1'b1;
    want = octant_code(vx, vy, vz, level_reg);
    if (has_code && want !== code) begin
      $error("normal_code: table expected %h predictor %h", code, want);
      fail_count++;
    end
    do @(posedge clk); while (in_stall);
    pending_codes.push_back(want);
  endtask

  // Drop valid, drain every expectation and let the pipe settle
  task automatic drain_pipe();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_level(logic [LVLW-1:0] lv);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= lv;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    level_reg = lv;
  endtask

  function automatic logic signed [15:0] rand_comp();
    unique case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'(int'($urandom_range(0, 8)) - 4);
      3: return 16'(int'($urandom_range(0, 512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [LVLW-1:0] lv_pick;
    level_reg = 4'd9;
    dir_rows = '{
      '{16'sd0, 16'sd0, 16'sd0, 1'b1, 31'd0},
      '{16'sh7FFF, 16'sd0, 16'sd0, 1'b0, 31'd0},
      '{16'sd0, 16'sh7FFF, 16'sd0, 1'b0, 31'd0},
      '{16'sd0, 16'sd0, 16'sh7FFF, 1'b0, 31'd0},
      '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 31'd0},
      '{16'sh8000, 16'sd0, 16'sd0, 1'b0, 31'd0},
      '{16'sd1, 16'sd1, 16'sd1, 1'b0, 31'd0},
      '{-16'sd1, 16'sd1, -16'sd1, 1'b0, 31'd0},
      '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0, 31'd0},
      '{16'sd100, 16'sd200, 16'sd300, 1'b0, 31'd0},
      '{-16'sd5, 16'sd3, 16'sd0, 1'b0, 31'd0},
      '{16'sd0, -16'sd7, 16'sh4000, 1'b0, 31'd0}
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows at the reset level and at level 14, extra vectors at level 0 and the saturating 15
    foreach (dir_rows[i])
      send_vector(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].has_code,
                  dir_rows[i].code);
    drain_pipe();
    write_level(4'd0);
    send_vector(-16'sd3, 16'sh8000, -16'sd9, 1'b1, 31'd0);
    send_vector(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1, 31'd0);
    drain_pipe();
    write_level(4'd14);
    foreach (dir_rows[i])
      send_vector(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, 1'b0, '0);
    drain_pipe();
    write_level(4'd15);
    send_vector(16'sh8000, 16'sd1, -16'sd1, 1'b0, '0);
    send_vector(16'sd0, 16'sd0, 16'sd0, 1'b1, 31'd0);

    // Random phases across levels; one with a long receiver hold-off
    for (int ph = 0; ph < 8; ph++) begin
      drain_pipe();
      lv_pick = (ph == 0) ? 4'd1 : (ph == 1) ? 4'd14 : 4'($urandom_range(0, 15));
      write_level(lv_pick);
      if (ph == 2) hold_receiver = 1'b1;
      if (ph == 7) quiet_tail = 1'b1;
      for (int n = 0; n < N_RANDOM / 8; n++)
        send_vector(rand_comp(), rand_comp(), rand_comp(), 1'b0, '0);
    end
    drain_pipe();

    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
